@@ hdl/lrf_pkg.sv @@
// Shared constants, types and tables for the linear resampler with fade-out.
package lrf_pkg;

   // Store geometry and fade length
   localparam int BUF_DEPTH   = 4096;
   localparam int CHANNELS    = 2;
   localparam int FADE_LEN    = 40;
   localparam int ADDR_W      = $clog2(BUF_DEPTH);
   localparam int STORE_AW    = ADDR_W + 1;
   localparam int STORE_DEPTH = 2 ** STORE_AW;

   // Field and register widths
   localparam int SAMPLE_W   = 24;
   localparam int POS_W      = 12;
   localparam int STEP_W     = 24;
   localparam int COUNT_W    = 13;
   localparam int BASE_W     = 12;
   localparam int ACT_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Arithmetic widths
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = POS_W + STEP_W;
   localparam int IDX_W       = PROD_W - FRAC_W + 1;
   localparam int LEN_W       = $clog2(FADE_LEN + 1);
   localparam int NUM_W       = LEN_W + FRAC_W;
   localparam int RECIP_SHIFT = NUM_W + LEN_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int FACTOR_W    = FRAC_W + 1;
   localparam int ACC_W       = 42;

   // Queue between front and back
   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Item actions
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PADDING  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PAST_END = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_INACTIVE = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RATIO      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COUNT       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_ENABLE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_BASE       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_END      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CHANNELS = 3'd6;

   typedef struct packed {
      logic [STEP_W-1:0]  step_ratio;
      logic [COUNT_W-1:0] out_count;
      logic [COUNT_W-1:0] frame_count;
      logic               fade_enable;
      logic [BASE_W-1:0]  read_base;
      logic [COUNT_W-1:0] source_end;
      logic [ACT_W-1:0]   active_channels;
   } cfg_type;

   typedef struct packed {
      logic                is_write;
      logic                channel;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] sample;
      logic [STATUS_W-1:0] status;
      logic [FRAC_W-1:0]   frac;
      logic [FACTOR_W-1:0] factor;
   } queue_item_type;

   // ceil(2^RECIP_SHIFT / len): exact quotient for numerators below 2^NUM_W
   typedef logic [RECIP_W-1:0] recip_table_type [0:FADE_LEN];

   function automatic recip_table_type build_recip_table();
      recip_table_type t;
      t[0] = '0;
      for (int l = 1; l <= FADE_LEN; l++) begin
         t[l] = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(l) - 64'd1) / 64'(l));
      end
      return t;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip_table();

endpackage

@@ hdl/linear_resampler_with_fadeout_top.sv @@
// Top level of the linear resampler with fade-out: registers and the front/queue/back split.
//
//  Channel  | Ports                                   | Direction | Moves
//  ---------+-----------------------------------------+-----------+------------------------------
//  request  | req_valid, req_stall, req_action,       | in        | one write or read transaction
//           | req_channel, req_position, req_sample_in|           |
//  response | rsp_valid, rsp_stall, rsp_sample_out,   | out       | one result per read
//           | rsp_out_channel, rsp_status             |           |
//  csr      | csr_write, csr_index, csr_wdata         | in        | one register write
//
//  One transaction is taken per cycle while req_stall is low; a read's result passes the second
//  front stage, one queue slot, four back stages from the store read on, then the result
//  register before it shows on rsp_valid.
//  The store has one write port and two read ports, so writes and reads share the same slot.
//  Synchronous reset clears the registers to their defaults and empties the pipes; the store
//  is not cleared and must be written before it is read.
//  A held result freezes the back part only; the front keeps taking transactions until the
//  8-entry queue is spoken for, then raises req_stall.
module linear_resampler_with_fadeout_top (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic                                 req_channel,
   input  logic [lrf_pkg::POS_W-1:0]            req_position,
   input  logic signed [lrf_pkg::SAMPLE_W-1:0]  req_sample_in,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [lrf_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   output logic                                 rsp_out_channel,
   output logic [lrf_pkg::STATUS_W-1:0]         rsp_status,

   input  logic                                 csr_write,
   input  logic [lrf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lrf_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   lrf_pkg::cfg_type                cfg_ff;

   logic                            push;
   lrf_pkg::queue_item_type         push_item;
   logic                            pop;
   lrf_pkg::queue_item_type         head;
   logic                            q_empty;
   logic [lrf_pkg::QCNT_W-1:0]      q_count;

   // Register file: take each write straight away, ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_ratio      <= lrf_pkg::STEP_W'(65536);
         cfg_ff.out_count       <= lrf_pkg::COUNT_W'(4096);
         cfg_ff.frame_count     <= lrf_pkg::COUNT_W'(4096);
         cfg_ff.fade_enable     <= 1'b0;
         cfg_ff.read_base       <= '0;
         cfg_ff.source_end      <= '0;
         cfg_ff.active_channels <= lrf_pkg::ACT_W'(2);
      end else if (csr_write) begin
         unique case (csr_index)
            lrf_pkg::CSR_STEP_RATIO: begin
               cfg_ff.step_ratio <= csr_wdata[lrf_pkg::STEP_W-1:0];
            end
            lrf_pkg::CSR_OUT_COUNT: begin
               cfg_ff.out_count <= csr_wdata[lrf_pkg::COUNT_W-1:0];
            end
            lrf_pkg::CSR_FRAME_COUNT: begin
               cfg_ff.frame_count <= csr_wdata[lrf_pkg::COUNT_W-1:0];
            end
            lrf_pkg::CSR_FADE_ENABLE: begin
               cfg_ff.fade_enable <= csr_wdata[0];
            end
            lrf_pkg::CSR_READ_BASE: begin
               cfg_ff.read_base <= csr_wdata[lrf_pkg::BASE_W-1:0];
            end
            lrf_pkg::CSR_SOURCE_END: begin
               cfg_ff.source_end <= csr_wdata[lrf_pkg::COUNT_W-1:0];
            end
            lrf_pkg::CSR_ACTIVE_CHANNELS: begin
               cfg_ff.active_channels <= csr_wdata[lrf_pkg::ACT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Front: accept, multiply out the position, classify, build the fade factor
   lrf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_channel   (req_channel),
      .req_position  (req_position),
      .req_sample_in (req_sample_in),
      .q_count       (q_count),
      .push          (push),
      .push_item     (push_item)
   );

   // Queue: decouple front from back so each side can stall on its own
   lrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .count     (q_count)
   );

   // Back: apply writes to the store, read neighbours, interpolate, fade, deliver
   lrf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_empty         (q_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_out_channel (rsp_out_channel),
      .rsp_status      (rsp_status)
   );

endmodule

@@ hdl/lrf_front.sv @@
// Front part: accept items, form the source position, classify and pre-compute the fade factor.
module lrf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  lrf_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic                          req_channel,
   input  logic [lrf_pkg::POS_W-1:0]     req_position,
   input  logic [lrf_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic [lrf_pkg::QCNT_W-1:0]    q_count,
   output logic                          push,
   output lrf_pkg::queue_item_type       push_item
);

   // Stage one: raw item and position product
   logic                           v1_ff;
   logic                           action1_ff;
   logic                           ch1_ff;
   logic [lrf_pkg::POS_W-1:0]      pos1_ff;
   logic [lrf_pkg::SAMPLE_W-1:0]   sample1_ff;
   logic [lrf_pkg::PROD_W-1:0]     prod1_ff;
   logic [lrf_pkg::PROD_W-1:0]     prod1_in;

   // Stage two: classified item
   logic                           v2_ff;
   logic                           keep2_ff;
   logic                           is_write2_ff;
   logic                           ch2_ff;
   logic [lrf_pkg::ADDR_W-1:0]     addr2_ff;
   logic [lrf_pkg::SAMPLE_W-1:0]   sample2_ff;
   logic [lrf_pkg::STATUS_W-1:0]   status2_ff;
   logic [lrf_pkg::FRAC_W-1:0]     frac2_ff;
   logic                           apply2_ff;
   logic [lrf_pkg::NUM_W-1:0]      num2_ff;
   logic [lrf_pkg::RECIP_W-1:0]    recip2_ff;

   logic                           accept;
   logic [lrf_pkg::QCNT_W:0]       occupancy;

   logic [lrf_pkg::FRAC_W-1:0]     frac;
   logic [lrf_pkg::IDX_W-1:0]      idx;
   logic [lrf_pkg::IDX_W-1:0]      idx_next;
   logic [lrf_pkg::COUNT_W-1:0]    end_eff;
   logic                           past_end;
   logic                           inactive;
   logic                           padding;
   logic                           write_ok;
   logic [lrf_pkg::STATUS_W-1:0]   status_in;
   logic [lrf_pkg::COUNT_W-1:0]    pos_ext;
   logic                           fade_on;
   logic [lrf_pkg::LEN_W-1:0]      len;
   logic [lrf_pkg::COUNT_W-1:0]    fade_start;
   logic [lrf_pkg::LEN_W-1:0]      k;
   logic [lrf_pkg::LEN_W-1:0]      len_left;
   logic                           apply_in;
   logic [lrf_pkg::NUM_W-1:0]      num_in;

   logic [lrf_pkg::NUM_W+lrf_pkg::RECIP_W-1:0] fade_prod;
   logic [lrf_pkg::FACTOR_W-1:0]   factor;

   // Hold off new items once everything in flight could fill the queue
   assign occupancy = (lrf_pkg::QCNT_W+1)'(q_count) + (lrf_pkg::QCNT_W+1)'(v1_ff)
                      + (lrf_pkg::QCNT_W+1)'(v2_ff);
   assign req_stall = occupancy >= (lrf_pkg::QCNT_W+1)'(lrf_pkg::QDEPTH);
   assign accept    = req_valid && !req_stall;

   assign prod1_in = lrf_pkg::PROD_W'(req_position) * lrf_pkg::PROD_W'(cfg.step_ratio);

   // Split position into whole index and fraction, and classify the item
   always_comb begin
      frac     = prod1_ff[lrf_pkg::FRAC_W-1:0];
      idx      = lrf_pkg::IDX_W'(cfg.read_base)
                 + lrf_pkg::IDX_W'(prod1_ff[lrf_pkg::PROD_W-1:lrf_pkg::FRAC_W]);
      idx_next = idx + lrf_pkg::IDX_W'(1);
      end_eff  = (cfg.source_end > lrf_pkg::COUNT_W'(lrf_pkg::BUF_DEPTH))
                 ? lrf_pkg::COUNT_W'(lrf_pkg::BUF_DEPTH) : cfg.source_end;
      past_end = (idx >= lrf_pkg::IDX_W'(end_eff))
                 || ((frac != '0) && (idx_next >= lrf_pkg::IDX_W'(end_eff)));
      pos_ext  = lrf_pkg::COUNT_W'(pos1_ff);
      inactive = ({1'b0, ch1_ff} >= cfg.active_channels)
                 || (32'(ch1_ff) >= 32'(lrf_pkg::CHANNELS));
      padding  = (pos_ext >= cfg.out_count) || (pos_ext >= cfg.frame_count);
      write_ok = (32'(ch1_ff) < 32'(lrf_pkg::CHANNELS))
                 && (32'(pos1_ff) < 32'(lrf_pkg::BUF_DEPTH));

      if (inactive) begin
         status_in = lrf_pkg::STATUS_INACTIVE;
      end else if (padding) begin
         status_in = lrf_pkg::STATUS_PADDING;
      end else if (past_end) begin
         status_in = lrf_pkg::STATUS_PAST_END;
      end else begin
         status_in = lrf_pkg::STATUS_OK;
      end
   end

   // Fade numerator (len-k)*2^16 + len/2 and the reciprocal of len
   always_comb begin
      fade_on    = cfg.fade_enable && (cfg.out_count < cfg.frame_count);
      len        = (cfg.out_count < lrf_pkg::COUNT_W'(lrf_pkg::FADE_LEN))
                   ? lrf_pkg::LEN_W'(cfg.out_count) : lrf_pkg::LEN_W'(lrf_pkg::FADE_LEN);
      fade_start = cfg.out_count - lrf_pkg::COUNT_W'(len);
      apply_in   = fade_on && (pos_ext >= fade_start) && (len != '0);
      k          = lrf_pkg::LEN_W'(pos_ext - fade_start);
      len_left   = len - k;
      num_in     = {len_left, lrf_pkg::FRAC_W'(0)} + lrf_pkg::NUM_W'(len >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action1_ff <= req_action;
         ch1_ff     <= req_channel;
         pos1_ff    <= req_position;
         sample1_ff <= req_sample_in;
         prod1_ff   <= prod1_in;
      end
      if (v1_ff) begin
         is_write2_ff <= (action1_ff == lrf_pkg::ACTION_WRITE);
         keep2_ff     <= (action1_ff == lrf_pkg::ACTION_READ) || write_ok;
         ch2_ff       <= ch1_ff;
         addr2_ff     <= (action1_ff == lrf_pkg::ACTION_WRITE)
                         ? lrf_pkg::ADDR_W'(pos1_ff) : idx[lrf_pkg::ADDR_W-1:0];
         sample2_ff   <= sample1_ff;
         status2_ff   <= status_in;
         frac2_ff     <= frac;
         apply2_ff    <= apply_in;
         num2_ff      <= num_in;
         recip2_ff    <= lrf_pkg::RECIP_TABLE[len];
      end
   end

   // Exact division by len through the reciprocal; unity factor when no fade
   assign fade_prod = (lrf_pkg::NUM_W+lrf_pkg::RECIP_W)'(num2_ff)
                      * (lrf_pkg::NUM_W+lrf_pkg::RECIP_W)'(recip2_ff);
   assign factor    = apply2_ff
                      ? lrf_pkg::FACTOR_W'(fade_prod >> lrf_pkg::RECIP_SHIFT)
                      : lrf_pkg::FACTOR_W'(1 << lrf_pkg::FRAC_W);

   assign push = v2_ff && keep2_ff;

   always_comb begin
      push_item          = '0;
      push_item.is_write = is_write2_ff;
      push_item.channel  = ch2_ff;
      push_item.addr     = addr2_ff;
      push_item.sample   = sample2_ff;
      push_item.status   = status2_ff;
      push_item.frac     = frac2_ff;
      push_item.factor   = factor;
   end

   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= (lrf_pkg::QCNT_W+1)'(lrf_pkg::QDEPTH))
      else $error("front occupancy exceeds queue depth");

endmodule

@@ hdl/lrf_queue.sv @@
// Short FIFO between the front and back parts.
module lrf_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  lrf_pkg::queue_item_type     push_item,
   input  logic                        pop,
   output lrf_pkg::queue_item_type     head,
   output logic                        empty,
   output logic [lrf_pkg::QCNT_W-1:0]  count
);

   lrf_pkg::queue_item_type            entries_ff [lrf_pkg::QDEPTH];
   logic [lrf_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [lrf_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [lrf_pkg::QCNT_W-1:0]         count_ff;
   logic                               full;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == lrf_pkg::QCNT_W'(lrf_pkg::QDEPTH));
   assign count = count_ff;
   assign head  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + lrf_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + lrf_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + lrf_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - lrf_pkg::QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && full |-> pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

@@ hdl/lrf_back.sv @@
// Back part: source store, interpolation, fade scaling and the result register.
module lrf_back (
   input  logic                               clock,
   input  logic                               reset,
   input  lrf_pkg::queue_item_type            head,
   input  logic                               q_empty,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lrf_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                               rsp_out_channel,
   output logic [lrf_pkg::STATUS_W-1:0]       rsp_status
);

   logic [lrf_pkg::SAMPLE_W-1:0]        store_mem [lrf_pkg::STORE_DEPTH];

   logic                                advance;
   logic [lrf_pkg::STORE_AW-1:0]        addr0;
   logic [lrf_pkg::STORE_AW-1:0]        addr1;

   // Stage B1: store read
   logic                                b1_valid_ff;
   logic                                b1_ch_ff;
   logic [lrf_pkg::STATUS_W-1:0]        b1_status_ff;
   logic [lrf_pkg::FRAC_W-1:0]          b1_frac_ff;
   logic [lrf_pkg::FACTOR_W-1:0]        b1_factor_ff;
   logic signed [lrf_pkg::SAMPLE_W-1:0] s0_ff;
   logic signed [lrf_pkg::SAMPLE_W-1:0] s1_ff;

   // Stage B2: weighted products
   logic                                b2_valid_ff;
   logic                                b2_ch_ff;
   logic [lrf_pkg::STATUS_W-1:0]        b2_status_ff;
   logic [lrf_pkg::FACTOR_W-1:0]        b2_factor_ff;
   logic signed [lrf_pkg::ACC_W-1:0]    p0_ff;
   logic signed [lrf_pkg::ACC_W-1:0]    p1_ff;
   logic signed [lrf_pkg::ACC_W-1:0]    p0_in;
   logic signed [lrf_pkg::ACC_W-1:0]    p1_in;
   logic [lrf_pkg::FACTOR_W-1:0]        w0;

   // Stage B3: interpolated sample
   logic                                b3_valid_ff;
   logic                                b3_ch_ff;
   logic [lrf_pkg::STATUS_W-1:0]        b3_status_ff;
   logic [lrf_pkg::FACTOR_W-1:0]        b3_factor_ff;
   logic signed [lrf_pkg::SAMPLE_W-1:0] interp_ff;
   logic signed [lrf_pkg::ACC_W-1:0]    interp_sum;

   // Stage B4: faded product
   logic                                b4_valid_ff;
   logic                                b4_ch_ff;
   logic [lrf_pkg::STATUS_W-1:0]        b4_status_ff;
   logic signed [lrf_pkg::ACC_W-1:0]    faded_ff;
   logic signed [lrf_pkg::ACC_W-1:0]    faded_in;
   logic signed [lrf_pkg::ACC_W-1:0]    faded_sum;

   // Result register
   logic                                rsp_valid_ff;
   logic                                rsp_ch_ff;
   logic [lrf_pkg::STATUS_W-1:0]        rsp_status_ff;
   logic signed [lrf_pkg::SAMPLE_W-1:0] rsp_sample_ff;
   logic signed [lrf_pkg::SAMPLE_W-1:0] sample_in;

   // Whole pipe moves unless a held result is not taken
   assign advance = !(rsp_valid_ff && rsp_stall);
   assign pop     = advance && !q_empty;

   assign addr0 = {head.channel, head.addr};
   assign addr1 = {head.channel, head.addr + lrf_pkg::ADDR_W'(1)};

   always_ff @(posedge clock) begin
      if (pop && head.is_write) begin
         store_mem[addr0] <= head.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff <= store_mem[addr0];
         s1_ff <= store_mem[addr1];
      end
   end

   always_comb begin
      w0    = lrf_pkg::FACTOR_W'(1 << lrf_pkg::FRAC_W) - lrf_pkg::FACTOR_W'(b1_frac_ff);
      p0_in = lrf_pkg::ACC_W'(s0_ff) * lrf_pkg::ACC_W'($signed({1'b0, w0}));
      // Drop the second neighbour entirely on a whole position
      if (b1_frac_ff == '0) begin
         p1_in = '0;
      end else begin
         p1_in = lrf_pkg::ACC_W'(s1_ff) * lrf_pkg::ACC_W'($signed({1'b0, b1_frac_ff}));
      end
      interp_sum = p0_ff + p1_ff + lrf_pkg::ACC_W'(32768);
      faded_in   = lrf_pkg::ACC_W'(interp_ff) * lrf_pkg::ACC_W'($signed({1'b0, b3_factor_ff}));
      faded_sum  = faded_ff + lrf_pkg::ACC_W'(32768);
      if (b4_status_ff == lrf_pkg::STATUS_OK) begin
         sample_in = faded_sum[lrf_pkg::FRAC_W +: lrf_pkg::SAMPLE_W];
      end else begin
         sample_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= pop && !head.is_write;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         b4_valid_ff  <= b3_valid_ff;
         rsp_valid_ff <= b4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_ch_ff      <= head.channel;
         b1_status_ff  <= head.status;
         b1_frac_ff    <= head.frac;
         b1_factor_ff  <= head.factor;

         b2_ch_ff      <= b1_ch_ff;
         b2_status_ff  <= b1_status_ff;
         b2_factor_ff  <= b1_factor_ff;
         p0_ff         <= p0_in;
         p1_ff         <= p1_in;

         b3_ch_ff      <= b2_ch_ff;
         b3_status_ff  <= b2_status_ff;
         b3_factor_ff  <= b2_factor_ff;
         interp_ff     <= interp_sum[lrf_pkg::FRAC_W +: lrf_pkg::SAMPLE_W];

         b4_ch_ff      <= b3_ch_ff;
         b4_status_ff  <= b3_status_ff;
         faded_ff      <= faded_in;

         rsp_ch_ff     <= b4_ch_ff;
         rsp_status_ff <= b4_status_ff;
         rsp_sample_ff <= sample_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_sample_out  = rsp_sample_ff;

   a_flagged_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != lrf_pkg::STATUS_OK) |-> rsp_sample_ff == '0)
      else $error("flagged result carries a non-zero sample");

   a_pop_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !pop)
      else $error("queue popped while the result is held");

endmodule
